[rtl/ipfmt_pkg.sv]
`timescale 1ns / 1ps

package ipfmt_pkg;

    localparam logic [1:0] FAM_V4 = 2'd0;
    localparam logic [1:0] FAM_V6 = 2'd1;

    localparam logic [1:0] STS_OK     = 2'd0;
    localparam logic [1:0] STS_NOFIT  = 2'd1;
    localparam logic [1:0] STS_BADFAM = 2'd2;

    localparam logic [6:0] CH_COLON = 7'h3a;
    localparam logic [6:0] CH_DOT   = 7'h2e;
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_NUL   = 7'h00;
    // 'a' minus ten
    localparam logic [6:0] CH_HEX_BASE = 7'h57;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISP,
        ST_SCAN,
        ST_LEN,
        ST_CHECK,
        ST_ERR,
        ST_WORD,
        ST_HEX,
        ST_TRAIL,
        ST_OCT,
        ST_DOT
    } t_state;

    typedef enum logic [2:0] {
        CS_NUL,
        CS_COLON,
        CS_DOT,
        CS_HEX,
        CS_DEC
    } t_csel;

    typedef struct packed {
        logic  load;
        logic  scan_step;
        logic  len_step;
        logic  idx_clr;
        logic  idx_inc;
        logic  idx_skip;
        logic  hex_init;
        logic  oct_first;
        logic  oct_next;
        logic  dig_dec;
        logic  emit;
        logic  last;
        t_csel csel;
    } t_cmd;

    typedef struct packed {
        logic [1:0] fam;
        logic       idx_last;
        logic       idx_zero;
        logic       in_run;
        logic       skip_end;
        logic       quad_here;
        logic       dig_zero;
        logic       oct_last;
        logic       fits;
    } t_stat;

    function automatic logic [6:0] hex_char(input logic [3:0] d);
        logic [6:0] r;
        if (d < 4'd10) r = CH_ZERO + {3'b000, d};
        else           r = CH_HEX_BASE + {3'b000, d};
        return r;
    endfunction

    // index of the top nonzero nibble, 0 for a zero word
    function automatic logic [1:0] hex_ndig_m1(input logic [15:0] w);
        logic [1:0] r;
        if (w[15:12] != 4'd0)     r = 2'd3;
        else if (w[11:8] != 4'd0) r = 2'd2;
        else if (w[7:4] != 4'd0)  r = 2'd1;
        else                      r = 2'd0;
        return r;
    endfunction

    function automatic logic [1:0] dec_ndig_m1(input logic [7:0] v);
        logic [1:0] r;
        if (v >= 8'd100)     r = 2'd2;
        else if (v >= 8'd10) r = 2'd1;
        else                 r = 2'd0;
        return r;
    endfunction

    // pos 2 hundreds, 1 tens, 0 ones
    function automatic logic [3:0] dec_digit(input logic [7:0] v, input logic [1:0] pos);
        logic [1:0]  h;
        logic [7:0]  rem8;
        logic [6:0]  rem;
        logic [14:0] prod;
        logic [3:0]  t;
        logic [6:0]  ones7;
        logic [3:0]  r;
        if (v >= 8'd200)      h = 2'd2;
        else if (v >= 8'd100) h = 2'd1;
        else                  h = 2'd0;
        case (h)
            2'd2:    rem8 = v - 8'd200;
            2'd1:    rem8 = v - 8'd100;
            default: rem8 = v;
        endcase
        rem   = rem8[6:0];
        // divide by ten via reciprocal, exact below 100
        prod  = {8'b0, rem} * 15'd205;
        t     = prod[14:11];
        ones7 = rem - ({3'b000, t} * 7'd10);
        case (pos)
            2'd2:    r = {2'b00, h};
            2'd1:    r = t;
            default: r = ones7[3:0];
        endcase
        return r;
    endfunction

    function automatic logic [7:0] quad_octet(input logic [31:0] q, input logic [1:0] sel);
        logic [7:0] r;
        case (sel)
            2'd0:    r = q[31:24];
            2'd1:    r = q[23:16];
            2'd2:    r = q[15:8];
            default: r = q[7:0];
        endcase
        return r;
    endfunction

endpackage

[rtl/ipfmt_ctrl.sv]
`timescale 1ns / 1ps

module ipfmt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  ipfmt_pkg::t_stat i_stat,
    output ipfmt_pkg::t_cmd  o_cmd,
    output logic             o_busy
);
    import ipfmt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.csel = CS_NUL;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DISP;
                end
            end
            ST_DISP: begin
                o_cmd.idx_clr = 1'b1;
                if (i_stat.fam == FAM_V4)      n_state = ST_LEN;
                else if (i_stat.fam == FAM_V6) n_state = ST_SCAN;
                else                           n_state = ST_ERR;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.idx_last) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = ST_LEN;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            ST_LEN: begin
                o_cmd.len_step = 1'b1;
                if (i_stat.fam == FAM_V4 || i_stat.idx_last) begin
                    n_state = ST_CHECK;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            ST_CHECK: begin
                o_cmd.idx_clr = 1'b1;
                if (!i_stat.fits) begin
                    n_state = ST_ERR;
                end else if (i_stat.fam == FAM_V4) begin
                    o_cmd.oct_first = 1'b1;
                    n_state         = ST_OCT;
                end else begin
                    n_state = ST_WORD;
                end
            end
            ST_ERR: begin
                o_cmd.emit = 1'b1;
                o_cmd.last = 1'b1;
                o_cmd.csel = CS_NUL;
                n_state    = ST_IDLE;
            end
            ST_WORD: begin
                if (i_stat.in_run) begin
                    // only reached at the start of the compressed run
                    o_cmd.emit = 1'b1;
                    o_cmd.csel = CS_COLON;
                    if (i_stat.skip_end) begin
                        n_state = ST_TRAIL;
                    end else begin
                        o_cmd.idx_skip = 1'b1;
                    end
                end else if (!i_stat.idx_zero) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.csel = CS_COLON;
                    if (i_stat.quad_here) begin
                        o_cmd.oct_first = 1'b1;
                        n_state         = ST_OCT;
                    end else begin
                        o_cmd.hex_init = 1'b1;
                        n_state        = ST_HEX;
                    end
                end else begin
                    o_cmd.hex_init = 1'b1;
                    n_state        = ST_HEX;
                end
            end
            ST_HEX: begin
                o_cmd.emit = 1'b1;
                o_cmd.csel = CS_HEX;
                if (i_stat.dig_zero) begin
                    if (i_stat.idx_last) begin
                        o_cmd.last = 1'b1;
                        n_state    = ST_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = ST_WORD;
                    end
                end else begin
                    o_cmd.dig_dec = 1'b1;
                end
            end
            ST_TRAIL: begin
                o_cmd.emit = 1'b1;
                o_cmd.last = 1'b1;
                o_cmd.csel = CS_COLON;
                n_state    = ST_IDLE;
            end
            ST_OCT: begin
                o_cmd.emit = 1'b1;
                o_cmd.csel = CS_DEC;
                if (i_stat.dig_zero) begin
                    if (i_stat.oct_last) begin
                        o_cmd.last = 1'b1;
                        n_state    = ST_IDLE;
                    end else begin
                        n_state = ST_DOT;
                    end
                end else begin
                    o_cmd.dig_dec = 1'b1;
                end
            end
            ST_DOT: begin
                o_cmd.emit     = 1'b1;
                o_cmd.csel     = CS_DOT;
                o_cmd.oct_next = 1'b1;
                n_state        = ST_OCT;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/ipfmt_dp.sv]
`timescale 1ns / 1ps

module ipfmt_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_opcode,
    input  logic [63:0]      i_addr_hi,
    input  logic [63:0]      i_addr_lo,
    input  logic [7:0]       i_buffer_size,
    input  ipfmt_pkg::t_cmd  i_cmd,
    output ipfmt_pkg::t_stat o_stat,
    output logic             o_strobe,
    output logic [6:0]       o_out_char,
    output logic             o_last,
    output logic [1:0]       o_status
);
    import ipfmt_pkg::*;

    // item registers
    logic [15:0] r_w [8];
    logic [31:0] r_quad;
    logic [1:0]  r_fam;
    logic [7:0]  r_cap;

    // zero-run search
    logic [2:0]  r_cur_base;
    logic [3:0]  r_cur_len;
    logic        r_cur_act;
    logic [2:0]  r_best_base;
    logic [3:0]  r_best_len;

    // walk position
    logic [2:0]  r_idx;
    logic [1:0]  r_dig;
    logic [1:0]  r_oct;
    logic [5:0]  r_len;

    // result register
    logic        r_strobe;
    logic [6:0]  r_char;
    logic        r_last;
    logic [1:0]  r_status;

    logic [15:0] cur_w;
    logic        wz;
    logic [2:0]  n_cur_base;
    logic [3:0]  n_cur_len;
    logic        n_cur_act;
    logic        cand_v;
    logic [2:0]  cand_base;
    logic [3:0]  cand_len;

    logic        run_ok;
    logic [3:0]  run_end;
    logic        in_run;
    logic        skip_end;
    logic        quad_case;
    logic [4:0]  quad_len;
    logic [5:0]  len_add;
    logic [8:0]  need;
    logic [7:0]  cur_oct;
    logic [7:0]  nxt_oct;
    logic [1:0]  oct_inc;
    logic [3:0]  nib;
    logic [6:0]  n_char;
    logic [1:0]  n_status;

    assign cur_w = r_w[r_idx];
    assign wz    = (cur_w == 16'd0);

    always_comb begin
        n_cur_base = r_cur_base;
        n_cur_len  = r_cur_len;
        n_cur_act  = r_cur_act;
        if (wz) begin
            if (r_cur_act) begin
                n_cur_len = r_cur_len + 4'd1;
            end else begin
                n_cur_base = r_idx;
                n_cur_len  = 4'd1;
                n_cur_act  = 1'b1;
            end
        end else begin
            n_cur_act = 1'b0;
        end
        // a run closes on a nonzero word or at the last word
        cand_v    = 1'b0;
        cand_base = r_cur_base;
        cand_len  = r_cur_len;
        if (!wz && r_cur_act) begin
            cand_v = 1'b1;
        end else if (wz && r_idx == 3'd7) begin
            cand_v    = 1'b1;
            cand_base = n_cur_base;
            cand_len  = n_cur_len;
        end
    end

    assign run_ok   = (r_best_len >= 4'd2);
    assign run_end  = {1'b0, r_best_base} + r_best_len;
    assign in_run   = run_ok && (r_idx >= r_best_base) && ({1'b0, r_idx} < run_end);
    assign skip_end = (run_end == 4'd8);
    assign quad_case = run_ok && (r_best_base == 3'd0) &&
                       ((r_best_len == 4'd6) ||
                        ((r_best_len == 4'd5) && (r_w[5] == 16'hffff)));

    assign quad_len = 5'd7 + {3'b000, dec_ndig_m1(r_quad[31:24])}
                           + {3'b000, dec_ndig_m1(r_quad[23:16])}
                           + {3'b000, dec_ndig_m1(r_quad[15:8])}
                           + {3'b000, dec_ndig_m1(r_quad[7:0])};

    always_comb begin
        if (in_run) begin
            len_add = (r_idx == r_best_base) ? 6'd1 : 6'd0;
        end else if (quad_case && r_idx == 3'd6) begin
            len_add = 6'd1 + {1'b0, quad_len};
        end else if (quad_case && r_idx == 3'd7) begin
            len_add = 6'd0;
        end else begin
            len_add = {5'b0, (r_idx != 3'd0)} + {4'b0, hex_ndig_m1(cur_w)} + 6'd1;
        end
        if (r_idx == 3'd7 && run_ok && skip_end) begin
            len_add = len_add + 6'd1;
        end
    end

    assign need    = {3'b000, r_len} + 9'd1;
    assign oct_inc = r_oct + 2'd1;
    assign cur_oct = quad_octet(r_quad, r_oct);
    assign nxt_oct = quad_octet(r_quad, oct_inc);

    always_comb begin
        case (r_dig)
            2'd3:    nib = cur_w[15:12];
            2'd2:    nib = cur_w[11:8];
            2'd1:    nib = cur_w[7:4];
            default: nib = cur_w[3:0];
        endcase
    end

    always_comb begin
        n_status = STS_OK;
        case (i_cmd.csel)
            CS_COLON: n_char = CH_COLON;
            CS_DOT:   n_char = CH_DOT;
            CS_HEX:   n_char = hex_char(nib);
            CS_DEC:   n_char = CH_ZERO + {3'b000, dec_digit(cur_oct, r_dig)};
            default: begin
                n_char   = CH_NUL;
                n_status = (r_fam == FAM_V4 || r_fam == FAM_V6) ? STS_NOFIT : STS_BADFAM;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int k = 0; k < 4; k++) begin
                r_w[k]     <= i_addr_hi[63 - 16 * k -: 16];
                r_w[k + 4] <= i_addr_lo[63 - 16 * k -: 16];
            end
            r_quad <= i_addr_lo[31:0];
            r_fam  <= i_opcode;
            r_cap  <= i_buffer_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_act  <= 1'b0;
            r_cur_base <= 3'd0;
            r_cur_len  <= 4'd0;
            r_best_base <= 3'd0;
            r_best_len <= 4'd0;
            r_idx      <= 3'd0;
            r_dig      <= 2'd0;
            r_oct      <= 2'd0;
            r_len      <= 6'd0;
        end else begin
            if (i_cmd.load) begin
                r_cur_act   <= 1'b0;
                r_cur_len   <= 4'd0;
                r_best_base <= 3'd0;
                r_best_len  <= 4'd0;
                r_len       <= 6'd0;
            end else if (i_cmd.scan_step) begin
                r_cur_base <= n_cur_base;
                r_cur_len  <= n_cur_len;
                r_cur_act  <= n_cur_act;
                if (cand_v && cand_len > r_best_len) begin
                    r_best_base <= cand_base;
                    r_best_len  <= cand_len;
                end
            end
            if (i_cmd.len_step) begin
                if (r_fam == FAM_V4) r_len <= {1'b0, quad_len};
                else                 r_len <= r_len + len_add;
            end
            if (i_cmd.idx_clr) begin
                r_idx <= 3'd0;
            end else if (i_cmd.idx_skip) begin
                r_idx <= run_end[2:0];
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 3'd1;
            end
            if (i_cmd.hex_init) begin
                r_dig <= hex_ndig_m1(cur_w);
            end else if (i_cmd.oct_first) begin
                r_oct <= 2'd0;
                r_dig <= dec_ndig_m1(quad_octet(r_quad, 2'd0));
            end else if (i_cmd.oct_next) begin
                r_oct <= oct_inc;
                r_dig <= dec_ndig_m1(nxt_oct);
            end else if (i_cmd.dig_dec) begin
                r_dig <= r_dig - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_char   <= n_char;
            r_last   <= i_cmd.last;
            r_status <= n_status;
        end
    end

    always_comb begin
        o_stat           = '0;
        o_stat.fam       = r_fam;
        o_stat.idx_last  = (r_idx == 3'd7);
        o_stat.idx_zero  = (r_idx == 3'd0);
        o_stat.in_run    = in_run;
        o_stat.skip_end  = skip_end;
        o_stat.quad_here = quad_case && (r_idx == 3'd6);
        o_stat.dig_zero  = (r_dig == 2'd0);
        o_stat.oct_last  = (r_oct == 2'd3);
        o_stat.fits      = (need <= {1'b0, r_cap});
    end

    assign o_strobe   = r_strobe;
    assign o_out_char = r_char;
    assign o_last     = r_last;
    assign o_status   = r_status;

endmodule

[rtl/ip_address_text_formatter_top.sv]
`timescale 1ns / 1ps

// ip address to text formatter
// input: pulse start with opcode (family), addr_hi/addr_lo and buffer_size;
// the transaction is taken at a clock edge with start high and busy low.
// output: one ascii character per o_strobe cycle, o_last on the final one,
// o_status 0; a text that does not fit (length plus terminator above
// buffer_size) or an unsupported family gives one result with char 0,
// o_last set and o_status 1 or 2.
// sequence: ipv4 passes the dispatch, length and check states, then gives
// one character a cycle; ipv6 passes dispatch, a zero-run search and a
// length count (one word at a time through the word register file), a
// check state, then one character a cycle with a pause when word 0 is
// printed. busy drops with the last result on the ports. the receiver
// cannot stall, so results are never held back.
// reset (synchronous, active low) aborts any transaction and clears the
// strobe; no result follows an aborted transaction.

module ip_address_text_formatter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [63:0] i_addr_hi,
    input  logic [63:0] i_addr_lo,
    input  logic [7:0]  i_buffer_size,
    output logic        o_strobe,
    output logic [6:0]  o_out_char,
    output logic        o_last,
    output logic [1:0]  o_status
);
    import ipfmt_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    ipfmt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    ipfmt_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_opcode      (i_opcode),
        .i_addr_hi     (i_addr_hi),
        .i_addr_lo     (i_addr_lo),
        .i_buffer_size (i_buffer_size),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_strobe      (o_strobe),
        .o_out_char    (o_out_char),
        .o_last        (o_last),
        .o_status      (o_status)
    );

endmodule

[rtl/ipfmt_chk.sv]
`timescale 1ns / 1ps

module ipfmt_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_strobe,
    input logic [6:0] o_out_char,
    input logic       o_last,
    input logic [1:0] o_status
);
    import ipfmt_pkg::*;

    // an error result stands alone
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status != STS_OK) |-> o_last && (o_out_char == CH_NUL))
        else $error("error result not single");

    a_ok_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status == STS_OK) |-> (o_out_char != CH_NUL))
        else $error("null character in text");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    // a transaction ends only with its last result
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) && $past(i_rst_n) |-> o_strobe && o_last)
        else $error("transaction ended without last result");

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy || $past(busy))
        else $error("result outside a transaction");

endmodule

bind ip_address_text_formatter_top ipfmt_chk u_ipfmt_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_strobe   (o_strobe),
    .o_out_char (o_out_char),
    .o_last     (o_last),
    .o_status   (o_status)
);
